// ===== src/plist_pkg.sv =====
// Shared constants, codes and types for the positional list engine.
`timescale 1ns / 1ps
package plist_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int OP_W   = 3;
   localparam int VAL_W  = 32;
   localparam int POS_W  = 5;
   localparam int ST_W   = 2;
   localparam int OCC_W  = 5;
   localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;

   localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
   localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        position;
   } plist_cmd_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [OCC_W-1:0] element_count;
   } plist_result_type;

endpackage

// ===== src/plist_if.sv =====
// Valid/ready channel interfaces for command and result items.
`timescale 1ns / 1ps
interface plist_req_if import plist_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic signed [VAL_W-1:0] value;
   logic [POS_W-1:0]        position;

   modport source (output valid, output operation, output value, output position,
                   input ready);
   modport sink (input valid, input operation, input value, input position,
                 output ready);
endinterface

interface plist_rsp_if import plist_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ST_W-1:0]  status;
   logic [OCC_W-1:0] element_count;

   modport source (output valid, output status, output element_count, input ready);
   modport sink (input valid, input status, input element_count, output ready);
endinterface

// ===== src/plist_core.sv =====
// Element store, occupancy and shift sequencer of the positional list engine.
`timescale 1ns / 1ps
module plist_core import plist_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  plist_cmd_type    cmd,
   output logic             idle,
   output logic             done_valid,
   input  logic             done_ready,
   output plist_result_type result
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_UP_RD = 3'd1;
   localparam logic [2:0] S_UP_WR = 3'd2;
   localparam logic [2:0] S_PUT   = 3'd3;
   localparam logic [2:0] S_DN_RD = 3'd4;
   localparam logic [2:0] S_DN_WR = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] tgt_ff, tgt_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [ST_W-1:0]   st_ff, st_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [VAL_W-1:0]  rd_data_ff;
   logic [VAL_W-1:0]  mem [DEPTH];

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [CMP_W-1:0]  pos_x;
   logic [CMP_W-1:0]  occ_x;
   logic [ADDR_W-1:0] ins_tgt;
   logic [ADDR_W-1:0] del_tgt;

   assign pos_x = CMP_W'(cmd.position);
   assign occ_x = CMP_W'(occ_ff);

   assign ins_tgt = (cmd.operation == OP_INS_FRONT) ? '0 :
                    (cmd.operation == OP_INS_BACK)  ? ADDR_W'(occ_ff) :
                                                      ADDR_W'(pos_x - CMP_W'(1));
   assign del_tgt = (cmd.operation == OP_DEL_FRONT) ? '0 :
                    (cmd.operation == OP_DEL_BACK)  ? ADDR_W'(occ_x - CMP_W'(1)) :
                                                      ADDR_W'(pos_x - CMP_W'(1));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      tgt_in   = tgt_ff;
      occ_in   = occ_ff;
      st_in    = st_ff;
      val_in   = val_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = rd_data_ff;
      rd_addr  = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               val_in   = cmd.value;
               st_in    = ST_DONE;
               state_in = S_DONE;
               unique case (cmd.operation) inside
                  OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
                     if (cmd.operation == OP_INS_POS &&
                         (pos_x == '0 || pos_x > occ_x + CMP_W'(1))) begin
                        st_in = ST_BADPOS;
                     end else if (occ_ff == CNT_W'(DEPTH)) begin
                        st_in = ST_FULL;
                     end else begin
                        idx_in   = ADDR_W'(occ_ff);
                        tgt_in   = ins_tgt;
                        state_in = S_UP_RD;
                     end
                  end
                  OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
                     if (cmd.operation == OP_DEL_POS &&
                         (pos_x == '0 || pos_x > occ_x)) begin
                        st_in = ST_BADPOS;
                     end else if (occ_ff == '0) begin
                        st_in = ST_EMPTY;
                     end else begin
                        idx_in   = del_tgt;
                        state_in = S_DN_RD;
                     end
                  end
                  default: begin
                     st_in = ST_DONE;
                  end
               endcase
            end
         end
         S_UP_RD: begin
            if (idx_ff == tgt_ff) begin
               state_in = S_PUT;
            end else begin
               rd_addr  = idx_ff - ADDR_W'(1);
               state_in = S_UP_WR;
            end
         end
         S_UP_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff - ADDR_W'(1);
            state_in = S_UP_RD;
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = tgt_ff;
            wr_data  = val_ff;
            occ_in   = occ_ff + CNT_W'(1);
            state_in = S_DONE;
         end
         S_DN_RD: begin
            if (CNT_W'(idx_ff) + CNT_W'(1) == occ_ff) begin
               occ_in   = occ_ff - CNT_W'(1);
               state_in = S_DONE;
            end else begin
               rd_addr  = idx_ff + ADDR_W'(1);
               state_in = S_DN_WR;
            end
         end
         S_DN_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff + ADDR_W'(1);
            state_in = S_DN_RD;
         end
         S_DONE: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
         st_ff    <= ST_DONE;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         st_ff    <= st_in;
      end
      idx_ff <= idx_in;
      tgt_ff <= tgt_in;
      val_ff <= val_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign idle                 = (state_ff == S_IDLE);
   assign done_valid           = (state_ff == S_DONE);
   assign result.status        = st_ff;
   assign result.element_count = OCC_W'(occ_ff);

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("occupancy beyond store depth");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == S_IDLE)
      else $error("command started while busy");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff != S_IDLE && state_ff != S_DONE)
      else $error("store written outside a command");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      done_valid && !done_ready |=> done_valid && $stable(result))
      else $error("result dropped or changed while held");

   a_noop_keeps: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && start && state_in == S_DONE |=> $stable(occ_ff))
      else $error("flagged command changed occupancy");

endmodule

// ===== src/positional_list_engine.sv =====
// Top level of the positional list engine: channel handshakes and result register.
`timescale 1ns / 1ps
// Holds an ordered list of up to 16 signed 32-bit values and runs one command at
// a time: insert or delete at the front, the back or a 1-based position, each
// answered by one item with a status and the element count after the command.
// Entries live in a single-port store with registered read, and one read/write
// pair moves each entry. An insert shifts the entries from its index on up one
// place and then writes the value; a delete shifts the entries after its index
// down one place. A flagged or unused command leaves the store untouched.
// A new command is taken once the previous result has been loaded into the
// output register, so a waiting result does not hold the next command off.
module positional_list_engine import plist_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   plist_req_if.sink req_ch,
   plist_rsp_if.source rsp_ch
);

   logic             core_idle;
   logic             start;
   logic             done_valid;
   logic             done_ready;
   plist_cmd_type    cmd;
   plist_result_type result;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]  status_ff;
   logic [OCC_W-1:0] count_ff;

   assign cmd.operation = req_ch.operation;
   assign cmd.value     = req_ch.value;
   assign cmd.position  = req_ch.position;
   assign req_ch.ready  = core_idle;
   assign start         = req_ch.valid && core_idle;
   assign done_ready    = !rsp_valid_ff || rsp_ch.ready;

   plist_core u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cmd        (cmd),
      .idle       (core_idle),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done_valid && done_ready) begin
         status_ff <= result.status;
         count_ff  <= result.element_count;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.element_count = count_ff;

endmodule
